// ===== sv/stereo_fir_convolver_defines.svh =====
// Assertion macros used by the stereo FIR convolver top level.
`ifndef STEREO_FIR_CONVOLVER_DEFINES_SVH
`define STEREO_FIR_CONVOLVER_DEFINES_SVH

`ifndef SYNTHESIS
`define SFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stereo_fir_convolver: same-cycle check failed");
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stereo_fir_convolver: next-cycle check failed");
`else
`define SFC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/sfc_pkg.sv =====
// Shared constants and types of the stereo FIR convolver.
`timescale 1ns / 1ps
package sfc_pkg;

    localparam int MAX_TAPS    = 1024;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;

    localparam int ADDR_W     = $clog2(MAX_TAPS);
    localparam int CNT_W      = $clog2(MAX_TAPS + 1);
    localparam int TAPCNT_W   = 11;
    localparam int TAPIDX_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS);

    typedef enum logic [1:0] {
        FUNC_FRAME = 2'd0,
        FUNC_TAP   = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ENABLED = 2'd0,
        CFG_TAP_COUNT      = 2'd1,
        CFG_SEPARATE_RIGHT = 2'd2,
        CFG_MONO_INPUT     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic              wr_hist;
        logic [ADDR_W-1:0] hist_wr_addr;
        logic [ADDR_W-1:0] hist_rd_addr;
        logic              wr_tap;
        logic [ADDR_W-1:0] tap_wr_addr;
        logic [ADDR_W-1:0] tap_rd_addr;
        logic              hist_ok;
        logic              clr_acc;
    } t_lane_ctl;

    typedef struct packed {
        logic load;
        logic pass;
    } t_merge_ctl;

endpackage

// ===== sv/sfc_if.sv =====
// Handshake interfaces for the frame, result and configuration channels.
`timescale 1ns / 1ps
interface sfc_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              func;
    logic signed [sfc_pkg::SAMPLE_BITS-1:0]  left_sample;
    logic signed [sfc_pkg::SAMPLE_BITS-1:0]  right_sample;
    logic                                    tap_channel;
    logic [sfc_pkg::TAPIDX_W-1:0]            tap_index;
    logic signed [sfc_pkg::COEF_BITS-1:0]    tap_value;

    modport source (output valid, func, left_sample, right_sample, tap_channel, tap_index,
                    tap_value, input ready);
    modport sink (input valid, func, left_sample, right_sample, tap_channel, tap_index,
                  tap_value, output ready);
endinterface

interface sfc_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [sfc_pkg::SAMPLE_BITS-1:0]  left_out;
    logic signed [sfc_pkg::SAMPLE_BITS-1:0]  right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink (input valid, left_out, right_out, output ready);
endinterface

interface sfc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sfc_pkg::CFG_IDX_W-1:0]     index;
    logic [sfc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/sfc_lane.sv =====
// One channel lane: sample history, tap memory and a pipelined multiply-accumulate.
`timescale 1ns / 1ps
module sfc_lane (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sfc_pkg::t_lane_ctl                     i_ctl,
    input  logic signed [sfc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic signed [sfc_pkg::COEF_BITS-1:0]   i_tap_value,
    input  logic signed [sfc_pkg::COEF_BITS-1:0]   i_coef,
    output logic signed [sfc_pkg::COEF_BITS-1:0]   o_tap_q,
    output logic signed [sfc_pkg::ACC_W-1:0]       o_acc
);

    logic signed [sfc_pkg::SAMPLE_BITS-1:0] r_hist_mem [sfc_pkg::MAX_TAPS];
    logic signed [sfc_pkg::COEF_BITS-1:0]   r_tap_mem  [sfc_pkg::MAX_TAPS];
    logic signed [sfc_pkg::SAMPLE_BITS-1:0] r_hist_q;
    logic signed [sfc_pkg::COEF_BITS-1:0]   r_tap_q;
    logic signed [sfc_pkg::PROD_W-1:0]      r_prod;
    logic signed [sfc_pkg::PROD_W-1:0]      w_prod;
    logic signed [sfc_pkg::ACC_W-1:0]       r_acc;
    logic                                   r_s1_vld;
    logic                                   r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_hist) begin
            r_hist_mem[i_ctl.hist_wr_addr] <= i_sample;
        end
        r_hist_q <= r_hist_mem[i_ctl.hist_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_tap) begin
            r_tap_mem[i_ctl.tap_wr_addr] <= i_tap_value;
        end
        r_tap_q <= r_tap_mem[i_ctl.tap_rd_addr];
    end

    assign w_prod = sfc_pkg::PROD_W'(r_hist_q) * sfc_pkg::PROD_W'(i_coef);

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_s1_vld <= i_ctl.hist_ok;
            r_s2_vld <= r_s1_vld;
            if (i_ctl.clr_acc) begin
                r_acc <= '0;
            end else if (r_s2_vld) begin
                r_acc <= r_acc + sfc_pkg::ACC_W'(r_prod);
            end
        end
    end

    assign o_tap_q = r_tap_q;
    assign o_acc   = r_acc;

endmodule

// ===== sv/sfc_merge.sv =====
// Loads the output register with rounded, saturated lane sums or passed samples.
`timescale 1ns / 1ps
module sfc_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sfc_pkg::t_merge_ctl                    i_ctl,
    input  logic signed [sfc_pkg::ACC_W-1:0]       i_acc_l,
    input  logic signed [sfc_pkg::ACC_W-1:0]       i_acc_r,
    input  logic signed [sfc_pkg::SAMPLE_BITS-1:0] i_pass_l,
    input  logic signed [sfc_pkg::SAMPLE_BITS-1:0] i_pass_r,
    output logic                                   o_free,
    sfc_out_if.source                              o_result
);

    localparam int RSH = sfc_pkg::COEF_BITS - 2;
    localparam logic signed [sfc_pkg::ACC_W:0] RND = (sfc_pkg::ACC_W + 1)'(2 ** (RSH - 1));
    localparam logic signed [sfc_pkg::ACC_W:0] SAT_HI =
        {{(sfc_pkg::ACC_W + 2 - sfc_pkg::SAMPLE_BITS){1'b0}},
         {(sfc_pkg::SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [sfc_pkg::ACC_W:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [sfc_pkg::SAMPLE_BITS-1:0] f_round_sat(
        input logic signed [sfc_pkg::ACC_W-1:0] acc
    );
        logic signed [sfc_pkg::ACC_W:0] v;
        logic signed [sfc_pkg::ACC_W:0] q;
        v = (sfc_pkg::ACC_W + 1)'(acc) + RND;
        q = v >>> RSH;
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[sfc_pkg::SAMPLE_BITS-1:0];
    endfunction

    logic                                   r_valid;
    logic signed [sfc_pkg::SAMPLE_BITS-1:0] r_left;
    logic signed [sfc_pkg::SAMPLE_BITS-1:0] r_right;

    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_left  <= i_ctl.pass ? i_pass_l : f_round_sat(i_acc_l);
            r_right <= i_ctl.pass ? i_pass_r : f_round_sat(i_acc_r);
        end
    end

    assign o_result.valid     = r_valid;
    assign o_result.left_out  = r_left;
    assign o_result.right_out = r_right;

endmodule

// ===== sv/stereo_fir_convolver.sv =====
// Top level of the stereo FIR convolver: sequencer, two MAC lanes and the output merge.
// A filtered frame runs from acceptance until its result is loaded into the output
// register, with tap_count capped at 1024 (zero goes straight to the drain state): one
// multiply-accumulate per tap in each of the two lanes, paced by the single read port of
// each history and tap memory, followed by the memory, multiplier and accumulator
// registers. A pass-through frame goes straight to the done state; tap writes and history
// clears act on acceptance. One item is worked on at a time; the next is accepted once the
// current result sits in the output register. A clear is immediate: a fill count marks how
// much of the history has been written since the last clear, so no clearing pass follows
// reset or a clear. Taps read before they are written give undefined results.
`timescale 1ns / 1ps
`include "stereo_fir_convolver_defines.svh"
module stereo_fir_convolver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfc_in_if.sink     i_frame,
    sfc_cfg_if.sink    i_cfg,
    sfc_out_if.source  o_result
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                                 r_state, n_state;
    logic [sfc_pkg::ADDR_W-1:0]             r_head, n_head;
    logic [sfc_pkg::ADDR_W-1:0]             r_base, n_base;
    logic [sfc_pkg::CNT_W-1:0]              r_fill, n_fill;
    logic [sfc_pkg::CNT_W-1:0]              r_k, n_k;
    logic [sfc_pkg::CNT_W-1:0]              r_n, n_n;
    logic                                   r_drain, n_drain;
    logic                                   r_pass, n_pass;
    logic signed [sfc_pkg::SAMPLE_BITS-1:0] r_pass_l, n_pass_l;
    logic signed [sfc_pkg::SAMPLE_BITS-1:0] r_pass_r, n_pass_r;

    logic                                   r_enable;
    logic [sfc_pkg::TAPCNT_W-1:0]           r_tap_count;
    logic                                   r_sep;
    logic                                   r_mono;

    logic                                   w_accept;
    sfc_pkg::t_func                         w_func;
    logic signed [sfc_pkg::SAMPLE_BITS-1:0] w_right_in;
    logic [sfc_pkg::CNT_W-1:0]              w_tap_lim;
    logic                                   w_idx_ok;
    logic [sfc_pkg::CNT_W-1:0]              w_slot;
    logic                                   w_frame_go;
    logic                                   w_out_free;

    sfc_pkg::t_lane_ctl                     w_ctl_l;
    sfc_pkg::t_lane_ctl                     w_ctl_r;
    sfc_pkg::t_merge_ctl                    w_merge_ctl;
    logic signed [sfc_pkg::COEF_BITS-1:0]   w_tap_q_l;
    logic signed [sfc_pkg::COEF_BITS-1:0]   w_tap_q_r;
    logic signed [sfc_pkg::COEF_BITS-1:0]   w_coef_r;
    logic signed [sfc_pkg::ACC_W-1:0]       w_acc_l;
    logic signed [sfc_pkg::ACC_W-1:0]       w_acc_r;

    assign i_frame.ready = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;

    assign w_accept   = i_frame.valid && i_frame.ready;
    assign w_func     = sfc_pkg::t_func'(i_frame.func);
    assign w_right_in = r_mono ? i_frame.left_sample : i_frame.right_sample;
    assign w_tap_lim  = (int'(r_tap_count) > sfc_pkg::MAX_TAPS)
                        ? sfc_pkg::CNT_W'(sfc_pkg::MAX_TAPS)
                        : sfc_pkg::CNT_W'(r_tap_count);
    assign w_idx_ok   = int'(i_frame.tap_index) < sfc_pkg::MAX_TAPS;
    assign w_slot     = (sfc_pkg::CNT_W'(r_base) >= r_k)
                        ? sfc_pkg::CNT_W'(r_base) - r_k
                        : sfc_pkg::CNT_W'(r_base) + sfc_pkg::CNT_W'(sfc_pkg::MAX_TAPS) - r_k;
    assign w_frame_go = w_accept && (w_func == sfc_pkg::FUNC_FRAME) && r_enable;

    always_comb begin
        w_ctl_l.wr_hist      = w_frame_go;
        w_ctl_l.hist_wr_addr = r_head;
        w_ctl_l.hist_rd_addr = w_slot[sfc_pkg::ADDR_W-1:0];
        w_ctl_l.wr_tap       = w_accept && (w_func == sfc_pkg::FUNC_TAP) && w_idx_ok
                               && !i_frame.tap_channel;
        w_ctl_l.tap_wr_addr  = sfc_pkg::ADDR_W'(i_frame.tap_index);
        w_ctl_l.tap_rd_addr  = r_k[sfc_pkg::ADDR_W-1:0];
        w_ctl_l.hist_ok      = (r_state == S_MAC) && (r_k < r_fill);
        w_ctl_l.clr_acc      = w_frame_go;
        w_ctl_r              = w_ctl_l;
        w_ctl_r.wr_tap       = w_accept && (w_func == sfc_pkg::FUNC_TAP) && w_idx_ok
                               && i_frame.tap_channel;
    end

    assign w_coef_r = r_sep ? w_tap_q_r : w_tap_q_l;

    sfc_lane u_lane_l (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl_l),
        .i_sample    (i_frame.left_sample),
        .i_tap_value (i_frame.tap_value),
        .i_coef      (w_tap_q_l),
        .o_tap_q     (w_tap_q_l),
        .o_acc       (w_acc_l)
    );

    sfc_lane u_lane_r (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl_r),
        .i_sample    (w_right_in),
        .i_tap_value (i_frame.tap_value),
        .i_coef      (w_coef_r),
        .o_tap_q     (w_tap_q_r),
        .o_acc       (w_acc_r)
    );

    assign w_merge_ctl.load = (r_state == S_DONE) && w_out_free;
    assign w_merge_ctl.pass = r_pass;

    sfc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_merge_ctl),
        .i_acc_l  (w_acc_l),
        .i_acc_r  (w_acc_r),
        .i_pass_l (r_pass_l),
        .i_pass_r (r_pass_r),
        .o_free   (w_out_free),
        .o_result (o_result)
    );

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_base   = r_base;
        n_fill   = r_fill;
        n_k      = r_k;
        n_n      = r_n;
        n_drain  = r_drain;
        n_pass   = r_pass;
        n_pass_l = r_pass_l;
        n_pass_r = r_pass_r;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_func)
                        sfc_pkg::FUNC_FRAME: begin
                            if (r_enable) begin
                                n_base  = r_head;
                                n_head  = (r_head == sfc_pkg::ADDR_W'(sfc_pkg::MAX_TAPS - 1))
                                          ? '0 : r_head + 1'b1;
                                n_fill  = (r_fill == sfc_pkg::CNT_W'(sfc_pkg::MAX_TAPS))
                                          ? r_fill : r_fill + 1'b1;
                                n_k     = '0;
                                n_n     = w_tap_lim;
                                n_pass  = 1'b0;
                                n_drain = 1'b0;
                                n_state = (w_tap_lim == '0) ? S_DRAIN : S_MAC;
                            end else begin
                                n_pass   = 1'b1;
                                n_pass_l = i_frame.left_sample;
                                n_pass_r = w_right_in;
                                n_state  = S_DONE;
                            end
                        end
                        sfc_pkg::FUNC_CLEAR: begin
                            n_head = '0;
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MAC: begin
                if (r_k == r_n - 1'b1) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_drain) begin
                    n_state = S_DONE;
                end else begin
                    n_drain = 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_base  <= '0;
            r_fill  <= '0;
            r_k     <= '0;
            r_n     <= '0;
            r_drain <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_base  <= n_base;
            r_fill  <= n_fill;
            r_k     <= n_k;
            r_n     <= n_n;
            r_drain <= n_drain;
            r_pass  <= n_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass_l <= n_pass_l;
        r_pass_r <= n_pass_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_tap_count <= sfc_pkg::TAPCNT_W'(1);
            r_sep       <= 1'b0;
            r_mono      <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (sfc_pkg::t_cfg_reg'(i_cfg.index))
                sfc_pkg::CFG_FILTER_ENABLED: r_enable    <= i_cfg.data[0];
                sfc_pkg::CFG_TAP_COUNT:      r_tap_count <= i_cfg.data[sfc_pkg::TAPCNT_W-1:0];
                sfc_pkg::CFG_SEPARATE_RIGHT: r_sep       <= i_cfg.data[0];
                sfc_pkg::CFG_MONO_INPUT:     r_mono      <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    `SFC_ASSERT_SAME(a_mac_in_range, i_clk, i_rst_n, r_state == S_MAC, r_k < r_n)
    `SFC_ASSERT_SAME(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= sfc_pkg::CNT_W'(sfc_pkg::MAX_TAPS))
    `SFC_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, w_merge_ctl.load, o_result.valid && r_state == S_IDLE)
    `SFC_ASSERT_NEXT(a_frame_busy, i_clk, i_rst_n, w_accept && (w_func == sfc_pkg::FUNC_FRAME), r_state != S_IDLE)

endmodule

// ===== sim/stereo_fir_convolver_tb.sv =====
// Self-checking testbench of the stereo FIR convolver with its own frame predictor.
`timescale 1ns / 1ps
module stereo_fir_convolver_tb;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic signed [sfc_pkg::SAMPLE_BITS-1:0] SMP_HI =
        {1'b0, {(sfc_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [sfc_pkg::SAMPLE_BITS-1:0] SMP_LO =
        {1'b1, {(sfc_pkg::SAMPLE_BITS-1){1'b0}}};
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef struct {
        logic [1:0]                             func;
        logic signed [sfc_pkg::SAMPLE_BITS-1:0] left_sample;
        logic signed [sfc_pkg::SAMPLE_BITS-1:0] right_sample;
        logic                                   tap_channel;
        logic [sfc_pkg::TAPIDX_W-1:0]           tap_index;
        logic signed [sfc_pkg::COEF_BITS-1:0]   tap_value;
    } t_conv_item;

    typedef struct {
        logic signed [sfc_pkg::SAMPLE_BITS-1:0] left_out;
        logic signed [sfc_pkg::SAMPLE_BITS-1:0] right_out;
    } t_frame_out;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_MOSTLY
    } t_sink_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sfc_in_if  frame_if ();
    sfc_cfg_if cfg_if ();
    sfc_out_if result_if ();

    stereo_fir_convolver uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_if),
        .i_cfg    (cfg_if),
        .o_result (result_if)
    );

    logic signed [sfc_pkg::SAMPLE_BITS-1:0] left_hist  [sfc_pkg::MAX_TAPS];
    logic signed [sfc_pkg::SAMPLE_BITS-1:0] right_hist [sfc_pkg::MAX_TAPS];
    logic [sfc_pkg::ADDR_W-1:0]             hist_head;
    logic signed [sfc_pkg::COEF_BITS-1:0]   left_coef  [sfc_pkg::MAX_TAPS];
    logic signed [sfc_pkg::COEF_BITS-1:0]   right_coef [sfc_pkg::MAX_TAPS];
    bit                                     left_loaded  [sfc_pkg::MAX_TAPS];
    bit                                     right_loaded [sfc_pkg::MAX_TAPS];

    bit                           cfg_enable;
    logic [sfc_pkg::TAPCNT_W-1:0] cfg_taps;
    bit                           cfg_sep;
    bit                           cfg_mono;

    t_frame_out  outputs_due[$];
    int unsigned error_count;
    int unsigned burst_left;
    bit          steady_sender;
    bit          hold_off_req;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic signed [sfc_pkg::SAMPLE_BITS-1:0] fir_sum(input bit right_lane);
        longint                     acc;
        longint                     q;
        logic [sfc_pkg::ADDR_W-1:0] slot;
        int                         n;
        acc = 0;
        n = (cfg_taps > sfc_pkg::MAX_TAPS) ? sfc_pkg::MAX_TAPS : int'(cfg_taps);
        for (int k = 0; k < n; k++) begin
            slot = hist_head - sfc_pkg::ADDR_W'(k);
            if (right_lane) begin
                acc += longint'(right_hist[slot]) *
                       longint'(cfg_sep ? right_coef[k] : left_coef[k]);
            end else begin
                acc += longint'(left_hist[slot]) * longint'(left_coef[k]);
            end
        end
        q = (acc + (longint'(1) << (sfc_pkg::COEF_BITS - 3))) >>> (sfc_pkg::COEF_BITS - 2);
        if (q > longint'(SMP_HI)) q = longint'(SMP_HI);
        if (q < longint'(SMP_LO)) q = longint'(SMP_LO);
        return sfc_pkg::SAMPLE_BITS'(q);
    endfunction

    function automatic bit apply_item(input t_conv_item it, output t_frame_out res);
        logic signed [sfc_pkg::SAMPLE_BITS-1:0] l;
        logic signed [sfc_pkg::SAMPLE_BITS-1:0] r;
        l = it.left_sample;
        r = cfg_mono ? it.left_sample : it.right_sample;
        res.left_out = '0;
        res.right_out = '0;
        case (it.func)
            sfc_pkg::FUNC_TAP: begin
                if (it.tap_channel) begin
                    right_coef[it.tap_index] = it.tap_value;
                    right_loaded[it.tap_index] = 1'b1;
                end else begin
                    left_coef[it.tap_index] = it.tap_value;
                    left_loaded[it.tap_index] = 1'b1;
                end
                return 1'b0;
            end
            sfc_pkg::FUNC_CLEAR: begin
                for (int k = 0; k < sfc_pkg::MAX_TAPS; k++) begin
                    left_hist[k] = '0;
                    right_hist[k] = '0;
                end
                hist_head = '0;
                return 1'b0;
            end
            sfc_pkg::FUNC_FRAME: begin
                if (!cfg_enable) begin
                    res.left_out = l;
                    res.right_out = r;
                    return 1'b1;
                end
                left_hist[hist_head] = l;
                right_hist[hist_head] = r;
                res.left_out = fir_sum(1'b0);
                res.right_out = fir_sum(1'b1);
                hist_head = hist_head + 1'b1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic signed [sfc_pkg::SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0: return SMP_HI;
            1: return SMP_LO;
            2: return '0;
            3: return '1;
            default: return sfc_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [sfc_pkg::COEF_BITS-1:0] rand_coef();
        logic signed [sfc_pkg::COEF_BITS-1:0] c;
        c = sfc_pkg::COEF_BITS'($urandom);
        if ($urandom_range(0, 2) != 0) c = c >>> $urandom_range(3, 12);
        return c;
    endfunction

    function automatic t_conv_item make_frame(
        input logic signed [sfc_pkg::SAMPLE_BITS-1:0] l,
        input logic signed [sfc_pkg::SAMPLE_BITS-1:0] r
    );
        t_conv_item it;
        it.func = sfc_pkg::FUNC_FRAME;
        it.left_sample = l;
        it.right_sample = r;
        it.tap_channel = 1'($urandom_range(0, 1));
        it.tap_index = sfc_pkg::TAPIDX_W'($urandom);
        it.tap_value = sfc_pkg::COEF_BITS'($urandom);
        return it;
    endfunction

    function automatic t_conv_item make_tap(
        input logic                                 chan,
        input logic [sfc_pkg::TAPIDX_W-1:0]         idx,
        input logic signed [sfc_pkg::COEF_BITS-1:0] value
    );
        t_conv_item it;
        it = make_frame(rand_sample(), rand_sample());
        it.func = sfc_pkg::FUNC_TAP;
        it.tap_channel = chan;
        it.tap_index = idx;
        it.tap_value = value;
        return it;
    endfunction

    function automatic t_conv_item rand_item();
        int unsigned pick;
        t_conv_item  it;
        pick = $urandom_range(0, 99);
        it = make_frame(rand_sample(), rand_sample());
        if (pick >= 95) begin
            it.func = FUNC_UNUSED;
        end else if (pick >= 89) begin
            it.func = sfc_pkg::FUNC_CLEAR;
        end else if (pick >= 74) begin
            it.func = sfc_pkg::FUNC_TAP;
            if ($urandom_range(0, 1)) begin
                it.tap_index = sfc_pkg::TAPIDX_W'($urandom_range(0, 63));
            end
            it.tap_value = rand_coef();
        end
        return it;
    endfunction

    task automatic send_item(input t_conv_item it);
        t_frame_out  res;
        int unsigned gap;
        @(negedge i_clk);
        if (!steady_sender) begin
            if (burst_left == 0) begin
                frame_if.valid = 1'b0;
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24)
                                                  : $urandom_range(1, 5);
                repeat (gap) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        frame_if.valid = 1'b1;
        frame_if.func = it.func;
        frame_if.left_sample = it.left_sample;
        frame_if.right_sample = it.right_sample;
        frame_if.tap_channel = it.tap_channel;
        frame_if.tap_index = it.tap_index;
        frame_if.tap_value = it.tap_value;
        do @(posedge i_clk); while (frame_if.ready !== 1'b1);
        if (apply_item(it, res)) outputs_due.push_back(res);
    endtask

    task automatic settle();
        @(negedge i_clk);
        frame_if.valid = 1'b0;
        while (outputs_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input sfc_pkg::t_cfg_reg idx,
                             input logic [sfc_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data = value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            sfc_pkg::CFG_FILTER_ENABLED: cfg_enable = value[0];
            sfc_pkg::CFG_TAP_COUNT:      cfg_taps = value[sfc_pkg::TAPCNT_W-1:0];
            sfc_pkg::CFG_SEPARATE_RIGHT: cfg_sep = value[0];
            sfc_pkg::CFG_MONO_INPUT:     cfg_mono = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Every tap that a filtered frame will read gets a value first, decaying with the index.
    task automatic load_taps();
        int n;
        n = (cfg_taps > sfc_pkg::MAX_TAPS) ? sfc_pkg::MAX_TAPS : int'(cfg_taps);
        for (int k = 0; k < n; k++) begin
            if (!left_loaded[k]) begin
                send_item(make_tap(1'b0, sfc_pkg::TAPIDX_W'(k),
                                   rand_coef() >>> (k < 8 ? 0 : 6 + k / 128)));
            end
            if (cfg_sep && !right_loaded[k]) begin
                send_item(make_tap(1'b1, sfc_pkg::TAPIDX_W'(k),
                                   rand_coef() >>> (k < 8 ? 0 : 6 + k / 128)));
            end
        end
    endtask

    task automatic configure(input bit enable, input logic [sfc_pkg::CFG_DATA_W-1:0] taps,
                             input bit sep, input bit mono);
        settle();
        write_reg(sfc_pkg::CFG_FILTER_ENABLED, sfc_pkg::CFG_DATA_W'(enable));
        write_reg(sfc_pkg::CFG_TAP_COUNT, taps);
        write_reg(sfc_pkg::CFG_SEPARATE_RIGHT, sfc_pkg::CFG_DATA_W'(sep));
        write_reg(sfc_pkg::CFG_MONO_INPUT, sfc_pkg::CFG_DATA_W'(mono));
        load_taps();
    endtask

    task automatic test_passthrough();
        send_item(make_frame(SMP_HI, SMP_LO));
        send_item(make_frame(SMP_LO, SMP_HI));
        send_item(make_frame('0, '1));
        configure(1'b0, 11'd1, 1'b0, 1'b1);
        send_item(make_frame(SMP_LO, 24'sd5));
        send_item(make_frame(24'sd123, SMP_HI));
    endtask

    task automatic test_zero_taps();
        configure(1'b1, 11'd0, 1'b0, 1'b0);
        send_item(make_frame(SMP_HI, SMP_LO));
        send_item(make_frame(SMP_LO, SMP_HI));
    endtask

    task automatic test_single_tap();
        send_item(make_tap(1'b0, '0, SMP_HI));
        send_item(make_tap(1'b1, '0, SMP_LO));
        send_item(make_tap(1'b0, '1, SMP_LO));
        send_item(make_tap(1'b1, '1, SMP_HI));
        configure(1'b1, 11'd1, 1'b1, 1'b0);
        send_item(make_frame(SMP_HI, SMP_HI));
        send_item(make_frame(SMP_LO, SMP_LO));
        send_item(make_frame(24'sd1, -24'sd1));
        send_item(make_frame(rand_sample(), rand_sample()));
    endtask

    task automatic test_clear_and_unused();
        t_conv_item it;
        configure(1'b1, 11'd2, 1'b0, 1'b0);
        send_item(make_frame(SMP_HI, 24'sd4096));
        send_item(make_frame(-24'sd77, SMP_LO));
        it = make_frame(rand_sample(), rand_sample());
        it.func = sfc_pkg::FUNC_CLEAR;
        send_item(it);
        send_item(make_frame(24'sd1000, -24'sd1000));
        it = make_frame(rand_sample(), rand_sample());
        it.func = FUNC_UNUSED;
        send_item(it);
        send_item(make_frame(rand_sample(), rand_sample()));
    endtask

    task automatic test_full_length();
        configure(1'b1, 11'd1024, 1'b0, 1'b0);
        repeat (3) send_item(make_frame(rand_sample(), rand_sample()));
        configure(1'b1, 11'd2047, 1'b1, 1'b1);
        repeat (3) send_item(make_frame(rand_sample(), rand_sample()));
    endtask

    task automatic test_backpressure();
        configure(1'b1, 11'd4, 1'b1, 1'b0);
        hold_off_req = 1'b1;
        steady_sender = 1'b1;
        repeat (10) send_item(make_frame(rand_sample(), rand_sample()));
        steady_sender = 1'b0;
        settle();
    endtask

    task automatic test_random_traffic();
        int unsigned                    items;
        logic [sfc_pkg::CFG_DATA_W-1:0] taps;
        for (int round = 0; round < 12; round++) begin
            if (round % 6 == 5) begin
                taps = sfc_pkg::CFG_DATA_W'($urandom_range(900, 2047));
                items = 8;
            end else begin
                taps = sfc_pkg::CFG_DATA_W'($urandom_range(0, 40));
                items = 48;
            end
            configure($urandom_range(0, 4) != 0, taps, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            steady_sender = ($urandom_range(0, 3) == 0);
            repeat (items) send_item(rand_item());
            steady_sender = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_out want;
        if (i_rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (outputs_due.size() == 0) begin
                $error("unexpected result transaction: left_out %0d, right_out %0d",
                       result_if.left_out, result_if.right_out);
                error_count++;
            end else begin
                want = outputs_due.pop_front();
                if (result_if.left_out !== want.left_out) begin
                    $error("left_out mismatch: expected %0d, got %0d",
                           want.left_out, result_if.left_out);
                    error_count++;
                end
                if (result_if.right_out !== want.right_out) begin
                    $error("right_out mismatch: expected %0d, got %0d",
                           want.right_out, result_if.right_out);
                    error_count++;
                end
            end
        end
    end

    initial begin : result_sink
        t_sink_mode  mode;
        int unsigned mode_left;
        result_if.ready = 1'b0;
        mode = SINK_OPEN;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                result_if.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:   result_if.ready = 1'b1;
                SINK_COIN:   result_if.ready = 1'($urandom_range(0, 1));
                SINK_SPARSE: result_if.ready = ($urandom_range(0, 3) == 0);
                default:     result_if.ready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        frame_if.valid = 1'b0;
        frame_if.func = sfc_pkg::FUNC_FRAME;
        frame_if.left_sample = '0;
        frame_if.right_sample = '0;
        frame_if.tap_channel = 1'b0;
        frame_if.tap_index = '0;
        frame_if.tap_value = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = sfc_pkg::CFG_FILTER_ENABLED;
        cfg_if.data = '0;
        for (int k = 0; k < sfc_pkg::MAX_TAPS; k++) begin
            left_hist[k] = '0;
            right_hist[k] = '0;
            left_coef[k] = '0;
            right_coef[k] = '0;
            left_loaded[k] = 1'b0;
            right_loaded[k] = 1'b0;
        end
        hist_head = '0;
        cfg_enable = 1'b0;
        cfg_taps = 11'd1;
        cfg_sep = 1'b0;
        cfg_mono = 1'b0;
        error_count = 0;
        burst_left = 0;
        steady_sender = 1'b0;
        hold_off_req = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_passthrough();
        test_zero_taps();
        test_single_tap();
        test_clear_and_unused();
        test_full_length();
        test_backpressure();
        test_random_traffic();

        settle();
        repeat (40) @(posedge i_clk);
        if (outputs_due.size() != 0) begin
            $error("%0d frame results never arrived", outputs_due.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
